### rtl/tmu_pkg.sv
// Shared types, constants and arithmetic helpers of the transform matrix unit.
`default_nettype none

package tmu_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned FRAC_W = 16;

  typedef logic signed [WORD_W-1:0] word_t;

  localparam word_t WMAX    = 32'sh7FFFFFFF;
  localparam word_t WMIN    = 32'sh80000000;
  localparam word_t ONE     = 32'sh00010000;
  localparam word_t TWO     = 32'sh00020000;
  localparam word_t NEG_ONE = 32'shFFFF0000;

  localparam int unsigned IN_W  = 136;
  localparam int unsigned OUT_W = 40;

  localparam int unsigned DIV_N     = 80;
  localparam int unsigned DIV_D     = 64;
  localparam int unsigned RED_SHIFT = 60 - FRAC_W;

  localparam logic [DIV_D-1:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;

  localparam int unsigned ZW = 36;
  localparam int unsigned XW = 34;

  localparam logic signed [ZW-1:0] PI_Q30      = 36'sh0C90FDAA2;
  localparam logic signed [ZW-1:0] TWO_PI_Q30  = 36'sh1921FB544;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sh06487ED51;
  localparam logic signed [XW-1:0] CORDIC_X0   = 34'sh26DD3B6A;

  typedef enum logic [2:0] {
    OP_IDENT = 3'd0,
    OP_TRANS = 3'd1,
    OP_ROTX  = 3'd2,
    OP_ROTY  = 3'd3,
    OP_ROTZ  = 3'd4,
    OP_PERSP = 3'd5
  } opcode_e;

  function automatic word_t sat_add(input word_t a, input word_t b);
    logic signed [WORD_W:0] s;
    s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
    if (s[WORD_W] != s[WORD_W-1]) begin
      return s[WORD_W] ? WMIN : WMAX;
    end
    return s[WORD_W-1:0];
  endfunction

  function automatic word_t sat_neg(input word_t v);
    if (v == WMIN) begin
      return WMAX;
    end
    return -v;
  endfunction

  function automatic word_t clamp48(input logic signed [47:0] v);
    if (v > 48'sd2147483647) begin
      return WMAX;
    end else if (v < -48'sd2147483648) begin
      return WMIN;
    end
    return v[WORD_W-1:0];
  endfunction

  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'h3243F6A8;
      5'd1:  r = 32'h1DAC6705;
      5'd2:  r = 32'h0FADBAFC;
      5'd3:  r = 32'h07F56EA6;
      5'd4:  r = 32'h03FEAB76;
      5'd5:  r = 32'h01FFD55B;
      5'd6:  r = 32'h00FFFAAA;
      5'd7:  r = 32'h007FFF55;
      5'd8:  r = 32'h003FFFEA;
      5'd9:  r = 32'h001FFFFD;
      5'd10: r = 32'h000FFFFF;
      5'd11: r = 32'h0007FFFF;
      5'd12: r = 32'h0003FFFF;
      5'd13: r = 32'h0001FFFF;
      5'd14: r = 32'h0000FFFF;
      5'd15: r = 32'h00007FFF;
      5'd16: r = 32'h00003FFF;
      5'd17: r = 32'h00001FFF;
      5'd18: r = 32'h00000FFF;
      5'd19: r = 32'h000007FF;
      5'd20: r = 32'h000003FF;
      5'd21: r = 32'h000001FF;
      5'd22: r = 32'h000000FF;
      5'd23: r = 32'h0000007F;
      5'd24: r = 32'h0000003F;
      5'd25: r = 32'h0000001F;
      5'd26: r = 32'h0000000F;
      5'd27: r = 32'h00000007;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000000;
      5'd31: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/transform_matrix_unit.sv
// Top level of the 4x4 fixed-point transform matrix unit with its step sequencer.
//
// A request on the slave stream carries an opcode and four Q16.16 arguments and
// applies one operation to the stored column-major matrix. The block then sends
// all sixteen entries on the master stream in index order, tlast on index 15 and
// tuser set on every entry when a division by zero was saturated.
// The block takes one request at a time; s_axis_tready_o is high only while idle.
// A small sequencer steps through the operation on one shared multiply-accumulate
// unit, one bit-serial divider and one CORDIC unit. A stall by the receiver holds
// the current entry and the block waits.
// Reset loads the identity matrix and leaves the block idle.
`default_nettype none

module transform_matrix_unit #(
  parameter int unsigned CORDIC_STEPS = 20
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // opcode[2:0], arg0[34:3], arg1[66:35], arg2[98:67], arg3[130:99], zero pad
  input  logic [tmu_pkg::IN_W-1:0]   s_axis_tdata_i,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // entry_index[3:0], entry_value[35:4], zero pad
  output logic [tmu_pkg::OUT_W-1:0]  m_axis_tdata_o,
  output logic                       m_axis_tlast_o,
  // div_error[0]
  output logic                       m_axis_tuser_o
);

  typedef tmu_pkg::word_t word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT,
    S_CORD,
    S_EMIT
  } state_e;

  typedef enum logic [2:0] {
    U_MAC,
    U_DIV,
    U_RED,
    U_IDENT,
    U_PSET,
    U_NOP,
    U_END
  } uop_e;

  typedef enum logic [4:0] {
    SRC_M,
    SRC_A0,
    SRC_A1,
    SRC_A2,
    SRC_A3,
    SRC_S,
    SRC_C,
    SRC_RS,
    SRC_RNS,
    SRC_ONE,
    SRC_TWO,
    SRC_ACC,
    SRC_TMP,
    SRC_T,
    SRC_FY,
    SRC_NF,
    SRC_SUM23,
    SRC_DIF23,
    SRC_HALF
  } src_e;

  typedef enum logic [2:0] {
    D_NONE,
    D_M,
    D_TMP,
    D_T,
    D_FY,
    D_FX,
    D_NF
  } dst_e;

  state_e      state_q;
  logic [2:0]  op_q;
  word_t       a0_q, a1_q, a2_q, a3_q;
  word_t       s_q, c_q, tmp_q, t_q, fy_q, fx_q, nf_q;
  logic        err_q;
  logic [5:0]  step_q;
  logic [3:0]  emit_q;
  word_t       m_q [16];

  uop_e        u_kind;
  src_e        u_xsel;
  src_e        u_ysel;
  logic        u_load;
  logic [3:0]  u_ridx;
  dst_e        u_dst;
  logic [3:0]  u_widx;

  logic [5:0]  rstep;
  logic [1:0]  p_hi, q_hi;
  logic [3:0]  rd_idx;
  word_t       m_rd;
  word_t       rs, rns;
  word_t       src_val [32];
  word_t       opa, opb;
  logic [31:0] mag_a, mag_b;

  logic                         mac_start, mac_done;
  word_t                        mac_acc;
  logic                         div_start, div_done;
  logic [tmu_pkg::DIV_N-1:0]    div_dividend, div_quot;
  logic [tmu_pkg::DIV_D-1:0]    div_divisor, div_rem, rfix;
  logic                         cor_start, cor_done;
  logic signed [tmu_pkg::ZW-1:0] cor_z;
  word_t                        cor_sin, cor_cos;

  logic        q_neg;
  logic [80:0] q_one, q_lim, q_sat;
  word_t       fdiv_res;
  logic        wr_en;
  word_t       wr_val;

  // Sequencer decode: one step of the running operation.
  always_comb begin
    u_kind = U_END;
    u_xsel = SRC_ONE;
    u_ysel = SRC_ONE;
    u_load = 1'b1;
    u_ridx = '0;
    u_dst  = D_NONE;
    u_widx = '0;
    rstep  = step_q - 6'd1;
    unique case (op_q)
      tmu_pkg::OP_ROTX: begin p_hi = 2'd1; q_hi = 2'd2; end
      tmu_pkg::OP_ROTY: begin p_hi = 2'd0; q_hi = 2'd2; end
      default:          begin p_hi = 2'd0; q_hi = 2'd1; end
    endcase
    unique case (op_q)
      tmu_pkg::OP_IDENT: begin
        if (step_q == 6'd0) begin
          u_kind = U_IDENT;
        end
      end
      tmu_pkg::OP_TRANS: begin
        if (step_q < 6'd16) begin
          u_kind = U_MAC;
          u_ysel = SRC_M;
          unique case (step_q[1:0])
            2'd0: begin u_xsel = SRC_A0; u_ridx = {2'd0, step_q[3:2]}; end
            2'd1: begin u_xsel = SRC_A1; u_ridx = {2'd1, step_q[3:2]}; u_load = 1'b0; end
            2'd2: begin u_xsel = SRC_A2; u_ridx = {2'd2, step_q[3:2]}; u_load = 1'b0; end
            2'd3: begin
              u_xsel = SRC_M;
              u_ysel = SRC_ONE;
              u_ridx = {2'd3, step_q[3:2]};
              u_load = 1'b0;
              u_dst  = D_M;
              u_widx = {2'd3, step_q[3:2]};
            end
          endcase
        end
      end
      tmu_pkg::OP_ROTX, tmu_pkg::OP_ROTY, tmu_pkg::OP_ROTZ: begin
        if (step_q == 6'd0) begin
          u_kind = U_RED;
          u_xsel = SRC_A0;
        end else if (step_q < 6'd33) begin
          u_kind = U_MAC;
          u_ysel = SRC_M;
          unique case (rstep[2:0])
            3'd0: begin u_xsel = SRC_C; u_ridx = {p_hi, rstep[4:3]}; end
            3'd1: begin
              u_xsel = SRC_RS;
              u_ridx = {q_hi, rstep[4:3]};
              u_load = 1'b0;
              u_dst  = D_TMP;
            end
            3'd2: begin u_xsel = SRC_RNS; u_ridx = {p_hi, rstep[4:3]}; end
            3'd3: begin
              u_xsel = SRC_C;
              u_ridx = {q_hi, rstep[4:3]};
              u_load = 1'b0;
              u_dst  = D_M;
              u_widx = {q_hi, rstep[4:3]};
            end
            3'd4: begin
              u_xsel = SRC_TMP;
              u_ysel = SRC_ONE;
              u_dst  = D_M;
              u_widx = {p_hi, rstep[4:3]};
            end
            default: u_kind = U_NOP;
          endcase
        end
      end
      tmu_pkg::OP_PERSP: begin
        unique case (step_q)
          6'd0: begin u_kind = U_RED; u_xsel = SRC_HALF; end
          6'd1: begin u_kind = U_DIV; u_xsel = SRC_S; u_ysel = SRC_C; u_dst = D_T; end
          6'd2: begin u_kind = U_DIV; u_xsel = SRC_ONE; u_ysel = SRC_T; u_dst = D_FY; end
          6'd3: begin u_kind = U_DIV; u_xsel = SRC_FY; u_ysel = SRC_A1; u_dst = D_FX; end
          6'd4: begin u_kind = U_DIV; u_xsel = SRC_ONE; u_ysel = SRC_DIF23; u_dst = D_NF; end
          6'd5: u_kind = U_PSET;
          6'd6: begin
            u_kind = U_MAC;
            u_xsel = SRC_SUM23;
            u_ysel = SRC_NF;
            u_dst  = D_M;
            u_widx = 4'd10;
          end
          6'd7: begin u_kind = U_MAC; u_xsel = SRC_TWO; u_ysel = SRC_A2; end
          6'd8: begin u_kind = U_MAC; u_xsel = SRC_ACC; u_ysel = SRC_A3; end
          6'd9: begin
            u_kind = U_MAC;
            u_xsel = SRC_ACC;
            u_ysel = SRC_NF;
            u_dst  = D_M;
            u_widx = 4'd14;
          end
          default: u_kind = U_END;
        endcase
      end
      default: u_kind = U_END;
    endcase
  end

  // Operand selection.
  always_comb begin
    rd_idx = (state_q == S_EMIT) ? emit_q : u_ridx;
    m_rd   = m_q[rd_idx];
    rs     = (op_q == tmu_pkg::OP_ROTY) ? tmu_pkg::sat_neg(s_q) : s_q;
    rns    = tmu_pkg::sat_neg(rs);
    for (int i = 0; i < 32; i++) begin
      src_val[i] = '0;
    end
    src_val[SRC_M]     = m_rd;
    src_val[SRC_A0]    = a0_q;
    src_val[SRC_A1]    = a1_q;
    src_val[SRC_A2]    = a2_q;
    src_val[SRC_A3]    = a3_q;
    src_val[SRC_S]     = s_q;
    src_val[SRC_C]     = c_q;
    src_val[SRC_RS]    = rs;
    src_val[SRC_RNS]   = rns;
    src_val[SRC_ONE]   = tmu_pkg::ONE;
    src_val[SRC_TWO]   = tmu_pkg::TWO;
    src_val[SRC_ACC]   = mac_acc;
    src_val[SRC_TMP]   = tmp_q;
    src_val[SRC_T]     = t_q;
    src_val[SRC_FY]    = fy_q;
    src_val[SRC_NF]    = nf_q;
    src_val[SRC_SUM23] = tmu_pkg::sat_add(a2_q, a3_q);
    src_val[SRC_DIF23] = tmu_pkg::sat_add(a2_q, tmu_pkg::sat_neg(a3_q));
    src_val[SRC_HALF]  = a0_q >>> 1;
    opa   = src_val[u_xsel];
    opb   = src_val[u_ysel];
    mag_a = opa[31] ? 32'(32'd0 - opa) : 32'(opa);
    mag_b = opb[31] ? 32'(32'd0 - opb) : 32'(opb);
  end

  // Unit requests and result post-processing.
  always_comb begin
    mac_start = (state_q == S_ISSUE) && (u_kind == U_MAC);
    div_start = (state_q == S_ISSUE) &&
                (((u_kind == U_DIV) && (opb != '0)) || (u_kind == U_RED));
    if (u_kind == U_RED) begin
      div_dividend = tmu_pkg::DIV_N'(mag_a) << tmu_pkg::RED_SHIFT;
      div_divisor  = tmu_pkg::TWO_PI_Q60;
    end else begin
      div_dividend = tmu_pkg::DIV_N'(mag_a) << tmu_pkg::FRAC_W;
      div_divisor  = tmu_pkg::DIV_D'(mag_b);
    end
    rfix      = (opa[31] && (div_rem != '0)) ? tmu_pkg::TWO_PI_Q60 - div_rem : div_rem;
    cor_z     = $signed({2'b00, rfix[63:30]});
    cor_start = (state_q == S_WAIT) && (u_kind == U_RED) && div_done;

    q_neg    = opa[31] ^ opb[31];
    q_one    = {1'b0, div_quot} + 81'((q_neg && (div_rem != '0)) ? 1 : 0);
    q_lim    = q_neg ? 81'h80000000 : 81'h7FFFFFFF;
    q_sat    = (q_one > q_lim) ? q_lim : q_one;
    fdiv_res = q_neg ? 32'(32'd0 - q_sat[31:0]) : q_sat[31:0];

    wr_en = 1'b0;
    wr_val = fdiv_res;
    if ((state_q == S_ISSUE) && (u_kind == U_DIV) && (opb == '0)) begin
      wr_en  = 1'b1;
      wr_val = opa[31] ? tmu_pkg::WMIN : tmu_pkg::WMAX;
    end else if ((state_q == S_WAIT) && (u_kind == U_MAC) && mac_done) begin
      wr_en  = 1'b1;
      wr_val = mac_acc;
    end else if ((state_q == S_WAIT) && (u_kind == U_DIV) && div_done) begin
      wr_en = 1'b1;
    end
  end

  tmu_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mac_start),
    .load_i  (u_load),
    .x_i     (opa),
    .y_i     (opb),
    .done_o  (mac_done),
    .acc_o   (mac_acc)
  );

  tmu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  tmu_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .z_i     (cor_z),
    .done_o  (cor_done),
    .sin_o   (cor_sin),
    .cos_o   (cor_cos)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= '0;
      a0_q    <= '0;
      a1_q    <= '0;
      a2_q    <= '0;
      a3_q    <= '0;
      s_q     <= '0;
      c_q     <= '0;
      tmp_q   <= '0;
      t_q     <= '0;
      fy_q    <= '0;
      fx_q    <= '0;
      nf_q    <= '0;
      err_q   <= 1'b0;
      step_q  <= '0;
      emit_q  <= '0;
      for (int i = 0; i < 16; i++) begin
        m_q[i] <= (i % 5 == 0) ? tmu_pkg::ONE : '0;
      end
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid_i) begin
            op_q    <= s_axis_tdata_i[2:0];
            a0_q    <= s_axis_tdata_i[34:3];
            a1_q    <= s_axis_tdata_i[66:35];
            a2_q    <= s_axis_tdata_i[98:67];
            a3_q    <= s_axis_tdata_i[130:99];
            err_q   <= 1'b0;
            step_q  <= '0;
            state_q <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          unique case (u_kind)
            U_MAC, U_RED: state_q <= S_WAIT;
            U_DIV: begin
              if (opb == '0) begin
                err_q  <= 1'b1;
                step_q <= step_q + 6'd1;
              end else begin
                state_q <= S_WAIT;
              end
            end
            U_IDENT: begin
              for (int i = 0; i < 16; i++) begin
                m_q[i] <= (i % 5 == 0) ? tmu_pkg::ONE : '0;
              end
              step_q <= step_q + 6'd1;
            end
            U_PSET: begin
              for (int i = 0; i < 16; i++) begin
                m_q[i] <= (i == 0)  ? fx_q :
                          (i == 5)  ? fy_q :
                          (i == 11) ? tmu_pkg::NEG_ONE : '0;
              end
              step_q  <= step_q + 6'd1;
            end
            U_NOP: step_q <= step_q + 6'd1;
            U_END: begin
              emit_q  <= '0;
              state_q <= S_EMIT;
            end
            default: state_q <= S_IDLE;
          endcase
        end
        S_WAIT: begin
          if (((u_kind == U_MAC) && mac_done) || ((u_kind == U_DIV) && div_done)) begin
            step_q  <= step_q + 6'd1;
            state_q <= S_ISSUE;
          end else if ((u_kind == U_RED) && div_done) begin
            state_q <= S_CORD;
          end
        end
        S_CORD: begin
          if (cor_done) begin
            s_q     <= cor_sin;
            c_q     <= cor_cos;
            step_q  <= step_q + 6'd1;
            state_q <= S_ISSUE;
          end
        end
        S_EMIT: begin
          if (m_axis_tready_i) begin
            if (emit_q == 4'hF) begin
              state_q <= S_IDLE;
            end else begin
              emit_q <= emit_q + 4'd1;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (wr_en) begin
        unique case (u_dst)
          D_M:     m_q[u_widx] <= wr_val;
          D_TMP:   tmp_q <= wr_val;
          D_T:     t_q <= wr_val;
          D_FY:    fy_q <= wr_val;
          D_FX:    fx_q <= wr_val;
          D_NF:    nf_q <= wr_val;
          default: ;
        endcase
      end
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = (state_q == S_EMIT);
  assign m_axis_tdata_o  = {4'b0000, m_rd, emit_q};
  assign m_axis_tlast_o  = (emit_q == 4'hF);
  assign m_axis_tuser_o  = err_q;

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input ready while entries are being sent");

  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o) |=> s_axis_tready_o)
    else $error("block not idle after the last entry");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> (!s_axis_tready_o && !m_axis_tvalid_o))
    else $error("block not working after a request");

  a_unit_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mac_done && div_done))
    else $error("multiplier and divider finished together");

  a_err_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && $past(m_axis_tvalid_o)) |-> $stable(err_q))
    else $error("error flag changed during a run of entries");
`endif

endmodule

`default_nettype wire

### rtl/tmu_mac.sv
// Shared fixed-point multiply with saturating accumulate.
`default_nettype none

module tmu_mac (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          load_i,
  input  tmu_pkg::word_t x_i,
  input  tmu_pkg::word_t y_i,
  output logic          done_o,
  output tmu_pkg::word_t acc_o
);

  logic signed [63:0] prod_q;
  logic               pend_q;
  logic               load_q;
  logic               done_q;
  tmu_pkg::word_t     acc_q;
  tmu_pkg::word_t     fm;

  assign fm = tmu_pkg::clamp48(prod_q[63:16]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
      pend_q <= 1'b0;
      load_q <= 1'b0;
      done_q <= 1'b0;
      acc_q  <= '0;
    end else begin
      done_q <= pend_q;
      pend_q <= start_i;
      if (start_i) begin
        prod_q <= x_i * y_i;
        load_q <= load_i;
      end
      if (pend_q) begin
        acc_q <= load_q ? fm : tmu_pkg::sat_add(acc_q, fm);
      end
    end
  end

  assign done_o = done_q;
  assign acc_o  = acc_q;

endmodule

`default_nettype wire

### rtl/tmu_div.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module tmu_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [tmu_pkg::DIV_N-1:0]   dividend_i,
  input  logic [tmu_pkg::DIV_D-1:0]   divisor_i,
  output logic                        done_o,
  output logic [tmu_pkg::DIV_N-1:0]   quot_o,
  output logic [tmu_pkg::DIV_D-1:0]   rem_o
);

  localparam int unsigned N  = tmu_pkg::DIV_N;
  localparam int unsigned D  = tmu_pkg::DIV_D;
  localparam int unsigned CW = $clog2(N + 1);

  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [N-1:0]  n_q;
  logic [D-1:0]  r_q;
  logic [D-1:0]  d_q;
  logic [D:0]    r_sh;
  logic          ge;
  logic [D-1:0]  r_nx;

  assign r_sh = {r_q, n_q[N-1]};
  assign ge   = r_sh >= {1'b0, d_q};
  assign r_nx = ge ? D'(r_sh - {1'b0, d_q}) : r_sh[D-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      n_q    <= '0;
      r_q    <= '0;
      d_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        n_q    <= dividend_i;
        r_q    <= '0;
        d_q    <= divisor_i;
      end else if (busy_q) begin
        r_q   <= r_nx;
        n_q   <= {n_q[N-2:0], ge};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(N - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = n_q;
  assign rem_o  = r_q;

endmodule

`default_nettype wire

### rtl/tmu_cordic.sv
// Angle folding and iterative CORDIC rotation that yields sine and cosine.
`default_nettype none

module tmu_cordic #(
  parameter int unsigned STEPS = 20
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [tmu_pkg::ZW-1:0]      z_i,
  output logic                               done_o,
  output tmu_pkg::word_t                     sin_o,
  output tmu_pkg::word_t                     cos_o
);

  localparam int unsigned ZW = tmu_pkg::ZW;
  localparam int unsigned XW = tmu_pkg::XW;
  localparam int unsigned IW = $clog2(STEPS);
  localparam int unsigned OSH = 30 - tmu_pkg::FRAC_W;

  typedef enum logic [2:0] {
    C_IDLE,
    C_WRAP,
    C_FOLD,
    C_ITER,
    C_OUT
  } cstate_e;

  cstate_e               state_q;
  logic signed [XW-1:0]  x_q;
  logic signed [XW-1:0]  y_q;
  logic signed [ZW-1:0]  z_q;
  logic                  flip_q;
  logic [IW-1:0]         i_q;
  logic                  done_q;
  tmu_pkg::word_t        sin_q;
  tmu_pkg::word_t        cos_q;

  logic signed [XW-1:0]  dx;
  logic signed [XW-1:0]  dy;
  logic signed [ZW-1:0]  at;
  logic signed [XW-1:0]  xf;
  logic signed [XW-1:0]  yf;
  logic signed [XW-1:0]  xs;
  logic signed [XW-1:0]  ys;

  always_comb begin
    dx = y_q >>> i_q;
    dy = x_q >>> i_q;
    at = $signed({4'b0000, tmu_pkg::atan_q30(5'(i_q))});
    xf = flip_q ? -x_q : x_q;
    yf = flip_q ? -y_q : y_q;
    xs = xf >>> OSH;
    ys = yf >>> OSH;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      x_q     <= '0;
      y_q     <= '0;
      z_q     <= '0;
      flip_q  <= 1'b0;
      i_q     <= '0;
      done_q  <= 1'b0;
      sin_q   <= '0;
      cos_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        C_IDLE: begin
          if (start_i) begin
            z_q     <= z_i;
            state_q <= C_WRAP;
          end
        end
        C_WRAP: begin
          if (z_q > tmu_pkg::PI_Q30) begin
            z_q <= z_q - tmu_pkg::TWO_PI_Q30;
          end
          state_q <= C_FOLD;
        end
        C_FOLD: begin
          flip_q <= 1'b0;
          if (z_q > tmu_pkg::HALF_PI_Q30) begin
            z_q    <= z_q - tmu_pkg::PI_Q30;
            flip_q <= 1'b1;
          end else if (z_q < -tmu_pkg::HALF_PI_Q30) begin
            z_q    <= z_q + tmu_pkg::PI_Q30;
            flip_q <= 1'b1;
          end
          x_q     <= tmu_pkg::CORDIC_X0;
          y_q     <= '0;
          i_q     <= '0;
          state_q <= C_ITER;
        end
        C_ITER: begin
          if (!z_q[ZW-1]) begin
            x_q <= x_q - dx;
            y_q <= y_q + dy;
            z_q <= z_q - at;
          end else begin
            x_q <= x_q + dx;
            y_q <= y_q - dy;
            z_q <= z_q + at;
          end
          i_q <= i_q + 1'b1;
          if (i_q == IW'(STEPS - 1)) begin
            state_q <= C_OUT;
          end
        end
        C_OUT: begin
          sin_q   <= tmu_pkg::clamp48({{(48 - XW){ys[XW-1]}}, ys});
          cos_q   <= tmu_pkg::clamp48({{(48 - XW){xs[XW-1]}}, xs});
          done_q  <= 1'b1;
          state_q <= C_IDLE;
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign sin_o  = sin_q;
  assign cos_o  = cos_q;

endmodule

`default_nettype wire
